FILE: sv/vgrt_pkg.sv
// shared constants for the voxel grid ray traversal block
// no dependencies; imported by voxel_grid_ray_traversal and the testbench
package vgrt_pkg;

   localparam int GRID_SIZE_DEF = 32;
   localparam int ID_BITS_DEF   = 16;
   localparam int FRAC_BITS     = 10;
   localparam int DIR_FRAC      = 14;

   // ray parameter width and its saturation value (stands for infinity)
   localparam int T_BITS = 8 + FRAC_BITS;
   localparam logic [T_BITS-1:0] T_LIMIT = {T_BITS{1'b1}};

   // quotient bits of 2^(DIR_FRAC+FRAC_BITS) / |dir|
   localparam int QUO_BITS = DIR_FRAC + FRAC_BITS + 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RAY   = 1'b1;

   localparam logic [1:0] ST_WRITTEN  = 2'd0;
   localparam logic [1:0] ST_HIT      = 2'd1;
   localparam logic [1:0] ST_LEFT     = 2'd2;
   localparam logic [1:0] ST_EXCEEDED = 2'd3;

   localparam logic [1:0] NRM_NONE = 2'd0;

endpackage

FILE: sv/vgrt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on vgrt_pkg only by convention (nothing imported)
module vgrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/voxel_grid_ray_traversal.sv
// top level of the voxel grid ray traversal block
// uses vgrt_pkg and one vgrt_ram instance for the voxel store
//
// a cubic store of GRID_SIZE^3 block ids (zero = empty) sits in one ram.
// after reset the block clears the store, one voxel per cycle, over all
// GRID_SIZE^3 addresses; req_tready stays low during that pass. a write item
// goes from idle straight to the done state. a ray item first builds per-axis
// reciprocals with a shared bit-serial divider (divide, saturate, multiply
// and first-crossing states per axis), then walks voxels with one store read
// (S_READ) and then the id test and step (S_CHK) per voxel, then works out
// the end point (one multiply per axis). one item is worked at a time; a
// finished result waits in the output register while the next item is taken.
module voxel_grid_ray_traversal
   import vgrt_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int ID_BITS   = ID_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // voxel_x[4:0] voxel_y[9:5] voxel_z[14:10] block_id[30:15] origin_x[45:31]
   // origin_y[60:46] origin_z[75:61] dir_x[91:76] dir_y[107:92] dir_z[123:108]
   // max_distance[140:124], zero pad
   input  logic [143:0] req_tdata,
   // operation[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_x[6:0] hit_y[13:7] hit_z[20:14] hit_id[36:21] normal_axis[38:37]
   // normal_negative[39] end_x[57:40] end_y[75:58] end_z[93:76] travelled[111:94]
   output logic [111:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int DEPTH   = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int BIT_W   = $clog2(QUO_BITS);
   localparam int PROD_W  = T_BITS + FRAC_BITS + 1;

   // state codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DIV  = 4'd1;
   localparam logic [3:0] S_DSAT = 4'd2;
   localparam logic [3:0] S_DMUL = 4'd3;
   localparam logic [3:0] S_TMAX = 4'd4;
   localparam logic [3:0] S_READ = 4'd5;
   localparam logic [3:0] S_CHK  = 4'd6;
   localparam logic [3:0] S_EMUL = 4'd7;
   localparam logic [3:0] S_EADD = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]         state_ff;
   logic               clearing_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   // per-axis ray state
   logic [14:0]         p_ff     [3];
   logic signed [15:0]  d_ff     [3];
   logic [15:0]         mag_ff   [3];
   logic                pos_ff   [3];
   logic signed [6:0]   idx_ff   [3];
   logic [T_BITS-1:0]   delta_ff [3];
   logic [T_BITS-1:0]   tmax_ff  [3];
   logic [17:0]         end_ff   [3];

   logic [16:0]         maxd_ff;
   logic [T_BITS-1:0]   t_ff;
   logic [1:0]          ax_ff;
   logic [16:0]         rem_ff;
   logic [QUO_BITS-1:0] quo_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic [PROD_W-1:0]   dprod_ff;
   logic signed [34:0]  eprod_ff;
   logic [1:0]          status_ff;
   logic [15:0]         hit_id_ff;
   logic [1:0]          naxis_ff;
   logic                nneg_ff;

   logic                rsp_valid_ff;
   logic [111:0]        rsp_data_ff;
   logic [1:0]          rsp_user_ff;

   // ram ports
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ID_BITS-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ID_BITS-1:0]  ram_rd_data;

   // input fields
   logic [4:0]  in_vx, in_vy, in_vz;
   logic [15:0] in_id;
   logic [14:0] in_p [3];
   logic signed [15:0] in_d [3];
   logic [16:0] in_maxd;

   assign in_vx   = req_tdata[4:0];
   assign in_vy   = req_tdata[9:5];
   assign in_vz   = req_tdata[14:10];
   assign in_id   = req_tdata[30:15];
   assign in_p[0] = req_tdata[45:31];
   assign in_p[1] = req_tdata[60:46];
   assign in_p[2] = req_tdata[75:61];
   assign in_d[0] = req_tdata[91:76];
   assign in_d[1] = req_tdata[107:92];
   assign in_d[2] = req_tdata[123:108];
   assign in_maxd = req_tdata[140:124];

   logic accept;
   logic wr_in_grid;
   logic cur_in_grid;
   logic out_free;

   assign req_tready  = (state_ff == S_IDLE) && !clearing_ff;
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // a write only lands when the voxel lies inside the grid
   assign wr_in_grid  = (int'(in_vx) < GRID_SIZE) && (int'(in_vy) < GRID_SIZE) &&
                        (int'(in_vz) < GRID_SIZE);

   assign cur_in_grid = !idx_ff[0][6] && !idx_ff[1][6] && !idx_ff[2][6] &&
                        (int'(idx_ff[0]) < GRID_SIZE) && (int'(idx_ff[1]) < GRID_SIZE) &&
                        (int'(idx_ff[2]) < GRID_SIZE);

   // store port muxing: clearing pass or a write item
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      if (clearing_ff) begin
         ram_wr_en = 1'b1;
      end else if (accept && req_tuser == OP_WRITE && wr_in_grid) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ADDR_W'((int'(in_vx) * GRID_SIZE + int'(in_vy)) * GRID_SIZE +
                               int'(in_vz));
         ram_wr_data = ID_BITS'(in_id);
      end
   end

   assign ram_rd_en   = (state_ff == S_READ);
   assign ram_rd_addr = ADDR_W'((int'(idx_ff[0][5:0]) * GRID_SIZE + int'(idx_ff[1][5:0])) *
                                GRID_SIZE + int'(idx_ff[2][5:0]));

   vgrt_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // divider step: dividend is a single one bit at position QUO_BITS-1
   logic [16:0] div_shift;
   logic        div_ge;
   assign div_shift = {rem_ff[15:0], (bit_ff == BIT_W'(QUO_BITS - 1))};
   assign div_ge    = div_shift >= {1'b0, mag_ff[ax_ff]};

   // distance to the first boundary in the step direction
   logic [FRAC_BITS:0] bnd_dist;
   assign bnd_dist = pos_ff[ax_ff] ?
                     ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, p_ff[ax_ff][FRAC_BITS-1:0]} :
                     {1'b0, p_ff[ax_ff][FRAC_BITS-1:0]};

   // first crossing, saturated
   logic [PROD_W-FRAC_BITS-1:0] dprod_hi;
   assign dprod_hi = dprod_ff[PROD_W-1:FRAC_BITS];

   // axis choice: x only on a strict win, then y, then z
   logic [1:0] step_ax;
   always_comb begin
      if (tmax_ff[0] < tmax_ff[1]) begin
         step_ax = (tmax_ff[0] < tmax_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         step_ax = (tmax_ff[1] < tmax_ff[2]) ? 2'd1 : 2'd2;
      end
   end

   logic [T_BITS:0] tsum;
   assign tsum = {1'b0, tmax_ff[step_ax]} + {1'b0, delta_ff[step_ax]};

   // end point: floor((p << DIR_FRAC + t*d) >> DIR_FRAC), saturated to 18 bits
   logic signed [36:0] esum;
   logic signed [22:0] equo;
   logic [17:0]        esat;
   assign esum = signed'(37'({p_ff[ax_ff], {DIR_FRAC{1'b0}}})) + 37'(eprod_ff);
   assign equo = 23'(esum >>> DIR_FRAC);
   always_comb begin
      if (equo > 23'sd131071) begin
         esat = 18'h1FFFF;
      end else if (equo < -23'sd131072) begin
         esat = 18'h20000;
      end else begin
         esat = equo[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end

         // drained, unless a new item is loaded at the same edge
         if (rsp_valid_ff && rsp_tready && !(state_ff == S_DONE && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 3; i++) begin
                     p_ff[i]   <= in_p[i];
                     d_ff[i]   <= in_d[i];
                     mag_ff[i] <= in_d[i][15] ? 16'(-in_d[i]) : in_d[i];
                     pos_ff[i] <= !in_d[i][15] && (in_d[i] != 16'sd0);
                     end_ff[i] <= '0;
                     idx_ff[i] <= (req_tuser == OP_RAY) ?
                                  7'(in_p[i][14:FRAC_BITS]) : 7'sd0;
                  end
                  maxd_ff   <= in_maxd;
                  t_ff      <= '0;
                  ax_ff     <= 2'd0;
                  rem_ff    <= '0;
                  quo_ff    <= '0;
                  bit_ff    <= BIT_W'(QUO_BITS - 1);
                  hit_id_ff <= '0;
                  naxis_ff  <= NRM_NONE;
                  nneg_ff   <= 1'b0;
                  status_ff <= ST_WRITTEN;
                  state_ff  <= (req_tuser == OP_RAY) ? S_DIV : S_DONE;
               end
            end
            S_DIV: begin
               rem_ff <= div_ge ? div_shift - {1'b0, mag_ff[ax_ff]} : div_shift;
               quo_ff <= {quo_ff[QUO_BITS-2:0], div_ge};
               bit_ff <= bit_ff - BIT_W'(1);
               if (bit_ff == '0) begin
                  state_ff <= S_DSAT;
               end
            end
            S_DSAT: begin
               delta_ff[ax_ff] <= (quo_ff > QUO_BITS'(T_LIMIT)) ? T_LIMIT : T_BITS'(quo_ff);
               state_ff        <= S_DMUL;
            end
            S_DMUL: begin
               dprod_ff <= PROD_W'(delta_ff[ax_ff]) * PROD_W'(bnd_dist);
               state_ff <= S_TMAX;
            end
            S_TMAX: begin
               // a zero direction never crosses
               if (mag_ff[ax_ff] == '0 || dprod_hi > (PROD_W-FRAC_BITS)'(T_LIMIT)) begin
                  tmax_ff[ax_ff] <= T_LIMIT;
               end else begin
                  tmax_ff[ax_ff] <= T_BITS'(dprod_hi);
               end
               if (mag_ff[ax_ff] == '0) begin
                  delta_ff[ax_ff] <= T_LIMIT;
               end
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= BIT_W'(QUO_BITS - 1);
               if (ax_ff == 2'd2) begin
                  ax_ff    <= 2'd0;
                  state_ff <= S_READ;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= S_DIV;
               end
            end
            S_READ: begin
               if ({1'b0, t_ff} > (T_BITS+1)'(maxd_ff)) begin
                  status_ff <= ST_EXCEEDED;
                  naxis_ff  <= NRM_NONE;
                  nneg_ff   <= 1'b0;
                  state_ff  <= S_EMUL;
               end else if (!cur_in_grid) begin
                  status_ff <= ST_LEFT;
                  state_ff  <= S_EMUL;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (ram_rd_data != '0) begin
                  status_ff <= ST_HIT;
                  hit_id_ff <= 16'(ram_rd_data);
                  state_ff  <= S_EMUL;
               end else begin
                  idx_ff[step_ax]  <= idx_ff[step_ax] + (pos_ff[step_ax] ? 7'sd1 : -7'sd1);
                  t_ff             <= tmax_ff[step_ax];
                  tmax_ff[step_ax] <= tsum > {1'b0, T_LIMIT} ? T_LIMIT : T_BITS'(tsum);
                  naxis_ff         <= step_ax + 2'd1;
                  nneg_ff          <= pos_ff[step_ax];
                  state_ff         <= S_READ;
               end
            end
            S_EMUL: begin
               eprod_ff <= signed'({1'b0, t_ff}) * d_ff[ax_ff];
               state_ff <= S_EADD;
            end
            S_EADD: begin
               end_ff[ax_ff] <= esat;
               if (ax_ff == 2'd2) begin
                  state_ff <= S_DONE;
               end else begin
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= S_EMUL;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result payload, loaded when the item finishes
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {18'(t_ff), end_ff[2], end_ff[1], end_ff[0], nneg_ff, naxis_ff,
                         hit_id_ff, idx_ff[2], idx_ff[1], idx_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for voxel_grid_ray_traversal
// depends on vgrt_pkg and the block's rtl; keeps its own voxel store and ray walker
module tb_top;
   import vgrt_pkg::*;

   localparam int GRID       = 32;
   localparam int WDOG_LIMIT = 100000;
   localparam int RAND_ITEMS = 930;

   typedef struct packed {
      logic        op;
      logic [4:0]  vx, vy, vz;
      logic [15:0] id;
      logic [14:0] ox, oy, oz;
      logic [15:0] dx, dy, dz;
      logic [16:0] maxd;
   } ray_req_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  hx, hy, hz;
      logic [15:0] hid;
      logic [1:0]  axis;
      logic        neg;
      logic [17:0] ex, ey, ez;
      logic [17:0] trav;
   } walk_res_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   // mirror of the block's voxel store, all empty after reset
   logic [15:0] world [GRID*GRID*GRID];
   walk_res_t   pending[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   logic [7:0]  stall_pat = 8'hff;
   int          pat_age = 0;

   always #4 clock = ~clock;

   voxel_grid_ray_traversal dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // saturate a ray parameter at the infinity value
   function automatic longint clamp_t(longint v);
      return v > longint'(T_LIMIT) ? longint'(T_LIMIT) : v;
   endfunction

   // amanatides-woo walk over the mirrored store, fixed point as in the block
   function automatic walk_res_t trace_ray(ray_req_t r);
      longint    p[3], d[3], idx[3], stp[3], dl[3], tm[3];
      longint    t, mag, base, bnd_dist, s, q;
      int        ax, k;
      walk_res_t w;
      w = '0;
      p[0] = r.ox; p[1] = r.oy; p[2] = r.oz;
      d[0] = longint'(signed'(r.dx));
      d[1] = longint'(signed'(r.dy));
      d[2] = longint'(signed'(r.dz));
      for (int i = 0; i < 3; i++) begin
         mag    = d[i] < 0 ? -d[i] : d[i];
         base   = (p[i] >> FRAC_BITS) << FRAC_BITS;
         idx[i] = p[i] >> FRAC_BITS;
         stp[i] = d[i] > 0 ? 1 : -1;
         if (mag == 0) begin
            dl[i] = longint'(T_LIMIT);
            tm[i] = longint'(T_LIMIT);
         end else begin
            dl[i]    = clamp_t((longint'(1) << (DIR_FRAC + FRAC_BITS)) / mag);
            bnd_dist = d[i] > 0 ? base + (longint'(1) << FRAC_BITS) - p[i] : p[i] - base;
            tm[i]    = clamp_t((dl[i] * bnd_dist) >> FRAC_BITS);
         end
      end
      t  = 0;
      ax = -1;
      forever begin
         if (t > longint'(r.maxd)) begin
            w.status = ST_EXCEEDED;
            ax = -1;
            break;
         end
         if (idx[0] < 0 || idx[0] >= GRID || idx[1] < 0 || idx[1] >= GRID ||
             idx[2] < 0 || idx[2] >= GRID) begin
            w.status = ST_LEFT;
            break;
         end
         w.hid = world[idx[0]*GRID*GRID + idx[1]*GRID + idx[2]];
         if (w.hid != 0) begin
            w.status = ST_HIT;
            break;
         end
         // x wins only strictly, then y strictly over z, else z
         if (tm[0] < tm[1]) k = tm[0] < tm[2] ? 0 : 2;
         else               k = tm[1] < tm[2] ? 1 : 2;
         idx[k] += stp[k];
         t       = tm[k];
         tm[k]   = clamp_t(tm[k] + dl[k]);
         ax      = k;
      end
      if (w.status != ST_HIT) w.hid = '0;
      w.hx = idx[0][6:0]; w.hy = idx[1][6:0]; w.hz = idx[2][6:0];
      if (ax >= 0) begin
         w.axis = 2'(ax + 1);
         w.neg  = stp[ax] > 0;
      end else begin
         w.axis = NRM_NONE;
      end
      for (int i = 0; i < 3; i++) begin
         // floor of (p*2^14 + t*d) / 2^14, then clip to 18 signed bits
         s = (p[i] << DIR_FRAC) + t * d[i];
         q = s >>> DIR_FRAC;
         if (q > 131071)  q = 131071;
         if (q < -131072) q = -131072;
         if (i == 0) w.ex = q[17:0];
         if (i == 1) w.ey = q[17:0];
         if (i == 2) w.ez = q[17:0];
      end
      w.trav = t[17:0];
      return w;
   endfunction

   // expected result of one accepted item; writes update the mirror
   function automatic walk_res_t predict_item(ray_req_t r);
      walk_res_t w;
      w = '0;
      if (r.op == OP_WRITE) begin
         world[r.vx*GRID*GRID + r.vy*GRID + r.vz] = r.id;
         w.status = ST_WRITTEN;
      end else begin
         w = trace_ray(r);
      end
      return w;
   endfunction

   task automatic report(string field, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $time);
      errors++;
   endtask

   // sender: bursts of items with random gaps between them
   task automatic send_item(ray_req_t r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {3'b0, r.maxd, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox,
                     r.id, r.vz, r.vy, r.vx};
      do @(posedge clock); while (!req_tready);
      pending.push_back(predict_item(r));
   endtask

   // hold the sender off until every expected result has come
   task automatic drain_all();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   function automatic ray_req_t rand_noise();
      logic [159:0] noise;
      ray_req_t     r;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r     = noise[$bits(ray_req_t)-1:0];
      return r;
   endfunction

   function automatic ray_req_t mk_write(int x, int y, int z, int id);
      ray_req_t r;
      r    = rand_noise();
      r.op = OP_WRITE;
      r.vx = 5'(x); r.vy = 5'(y); r.vz = 5'(z); r.id = 16'(id);
      return r;
   endfunction

   function automatic ray_req_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int maxd);
      ray_req_t r;
      r    = rand_noise();
      r.op = OP_RAY;
      r.ox = 15'(ox); r.oy = 15'(oy); r.oz = 15'(oz);
      r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
      r.maxd = 17'(maxd);
      return r;
   endfunction

   // voxel center in q5.10
   function automatic int ctr(int v);
      return v * 1024 + 512;
   endfunction

   task automatic test_corner_writes();
      send_item(mk_write(0, 0, 0, 16'hffff));
      send_item(mk_write(31, 31, 31, 16'h0001));
      send_item(mk_write(31, 0, 0, 16'h8000));
      send_item(mk_write(0, 31, 0, 16'h5555));
      send_item(mk_write(0, 0, 31, 16'haaaa));
   endtask

   task automatic test_axis_rays();
      // start voxel solid: no normal
      send_item(mk_ray(ctr(0), ctr(0), ctr(0), 16384, 0, 0, 131071));
      send_item(mk_ray(ctr(5), ctr(0), ctr(0), 16384, 0, 0, 131071));
      send_item(mk_ray(ctr(5), ctr(0), ctr(0), -16384, 0, 0, 131071));
      send_item(mk_ray(ctr(0), ctr(5), ctr(0), 0, 16384, 0, 131071));
      send_item(mk_ray(ctr(0), ctr(0), ctr(5), 0, 0, 16384, 131071));
      send_item(mk_ray(ctr(10), ctr(0), ctr(10), 0, -16384, 0, 131071));
   endtask

   task automatic test_special_rays();
      // equal components: ties resolve toward z, then y
      send_item(mk_ray(ctr(28), ctr(28), ctr(28), 16384, 16384, 16384, 131071));
      send_item(mk_ray(ctr(3), ctr(3), ctr(3), -9000, -9000, -9000, 131071));
      // zero direction walks to infinity
      send_item(mk_ray(ctr(10), ctr(10), ctr(10), 0, 0, 0, 131071));
      // no distance allowed
      send_item(mk_ray(ctr(7), ctr(7), ctr(7), 1000, -2000, 3000, 0));
      send_item(mk_ray(32767, 32767, 32767, 16384, 1, 16384, 131071));
      send_item(mk_ray(0, 0, 0, 1, -1, -16384, 131071));
      send_item(mk_ray(ctr(12), ctr(20), ctr(4), -5, 16384, -16384, 5000));
      // clearing a voxel to empty lets the ray through
      send_item(mk_write(0, 0, 0, 0));
      send_item(mk_ray(ctr(5), ctr(0), ctr(0), -16384, 0, 0, 131071));
      drain_all();
   endtask

   function automatic int rand_dir();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $urandom_range(0, 64) - 32;
         2:       return $urandom_range(0, 1) ? 16384 : -16384;
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   task automatic test_random_mix();
      ray_req_t r;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            r = mk_write($urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31),
                         $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 65535));
         end else begin
            r = mk_ray($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), rand_dir(), rand_dir(), rand_dir(),
                       $urandom_range(0, 1) ? $urandom_range(0, 131071)
                                            : $urandom_range(0, 8191));
         end
         send_item(r);
         if (n % 300 == 150) drain_all();
      end
      req_tvalid <= 1'b0;
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      walk_res_t want, got;
      if (rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[6:0], rsp_tdata[13:7], rsp_tdata[20:14],
                rsp_tdata[36:21], rsp_tdata[38:37], rsp_tdata[39], rsp_tdata[57:40],
                rsp_tdata[75:58], rsp_tdata[93:76], rsp_tdata[111:94]};
         if (pending.size() == 0) begin
            report("unexpected item", 0, 1);
         end else begin
            want = pending.pop_front();
            if (got.status != want.status) report("status", want.status, got.status);
            if (got.hx != want.hx)         report("hit_x", want.hx, got.hx);
            if (got.hy != want.hy)         report("hit_y", want.hy, got.hy);
            if (got.hz != want.hz)         report("hit_z", want.hz, got.hz);
            if (got.hid != want.hid)       report("hit_id", want.hid, got.hid);
            if (got.axis != want.axis)     report("normal_axis", want.axis, got.axis);
            if (got.neg != want.neg)       report("normal_negative", want.neg, got.neg);
            if (got.ex != want.ex)         report("end_x", want.ex, got.ex);
            if (got.ey != want.ey)         report("end_y", want.ey, got.ey);
            if (got.ez != want.ez)         report("end_z", want.ez, got.ez);
            if (got.trav != want.trav)     report("travelled", want.trav, got.trav);
         end
      end
      pat_age <= pat_age + 1;
      if (pat_age % 97 == 0)
         stall_pat <= $urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom);
      else
         stall_pat <= {stall_pat[6:0], stall_pat[7]};
      rsp_tready <= stall_pat[0];
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (world[i]) world[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_corner_writes();
      test_axis_rays();
      test_special_rays();
      test_random_mix();
      while (pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
sv/vgrt_pkg.sv
sv/vgrt_ram.sv
sv/voxel_grid_ray_traversal.sv
verif/tb_top.sv
